/* rtl/core/isp_pkg.sv */
// ----------------------------------------------------------------------------
// isp_pkg: shared types and constants of the infix-to-postfix converter
// Holds the transfer payload structs, the operator codes, the sequencer
// states and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package isp_pkg;

  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

  // Bit 1 of the code set means multiplicative (higher) precedence.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_code_t;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              expr_end;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
    logic              postfix_end;
    logic              overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT_CHAR,
    ST_OP_POP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic out_load;
    logic out_sel_top;
    logic out_last;
    logic out_end;
    logic pop;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic in_is_op;
    logic item_end;
    logic item_high;
    logic count_zero;
    logic count_one;
    logic top_ge;
    logic out_free;
  } status_t;

  function automatic logic is_op_char(input logic [CHAR_W-1:0] c);
    return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_STAR) || (c == CHAR_SLASH);
  endfunction

  function automatic op_code_t char_to_code(input logic [CHAR_W-1:0] c);
    op_code_t code;
    case (c)
      CHAR_MINUS: code = OP_SUB;
      CHAR_STAR:  code = OP_MUL;
      CHAR_SLASH: code = OP_DIV;
      default:    code = OP_ADD;
    endcase
    return code;
  endfunction

  function automatic logic [CHAR_W-1:0] code_to_char(input op_code_t code);
    logic [CHAR_W-1:0] c;
    case (code)
      OP_SUB:  c = CHAR_MINUS;
      OP_MUL:  c = CHAR_STAR;
      OP_DIV:  c = CHAR_SLASH;
      default: c = CHAR_PLUS;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/isp_ctrl.sv */
// ----------------------------------------------------------------------------
// isp_ctrl: sequencer of the infix-to-postfix converter
// Walks each accepted character through emit, pop, push and flush steps
// and issues one command word per cycle to the datapath.
// ----------------------------------------------------------------------------
module isp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  isp_pkg::status_t status,
  output isp_pkg::cmd_t    cmd
);
  import isp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = status.in_is_op ? ST_OP_POP : ST_EMIT_CHAR;
        end
      end
      ST_EMIT_CHAR: begin
        if (status.out_free) begin
          state_next = (status.item_end && !status.count_zero) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_OP_POP: begin
        if (status.count_zero || !status.top_ge) begin
          state_next = status.item_end ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status.out_free && status.count_one) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.load_item = item_valid;
      end
      ST_EMIT_CHAR: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = !(status.item_end && !status.count_zero);
          cmd.out_end  = status.item_end && status.count_zero;
        end
      end
      ST_OP_POP: begin
        if (!status.count_zero && status.top_ge) begin
          if (status.out_free) begin
            cmd.out_load    = 1'b1;
            cmd.out_sel_top = 1'b1;
            cmd.pop         = 1'b1;
            cmd.out_last    = !status.item_end && (status.count_one || status.item_high);
          end
        end else begin
          cmd.push = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_sel_top = 1'b1;
          cmd.pop         = 1'b1;
          cmd.out_last    = status.count_one;
          cmd.out_end     = status.count_one;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/isp_datapath.sv */
// ----------------------------------------------------------------------------
// isp_datapath: operator stack, item register and result register
// The stack memory keeps a registered copy of its top entry, refreshed
// every cycle with write-through so that pops can follow back to back.
// ----------------------------------------------------------------------------
module isp_datapath #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  isp_pkg::in_item_t item,
  input  isp_pkg::cmd_t     cmd,
  output isp_pkg::status_t  status,
  output logic              result_valid,
  input  logic              result_stall,
  output isp_pkg::out_item_t result
);
  import isp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  op_code_t          op_mem [STACK_DEPTH];
  op_code_t          top;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     count_dec_next;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              full;
  logic              mem_we;
  logic              ovf;
  logic [CHAR_W-1:0] item_char;
  logic              item_end;
  op_code_t          item_code;

  assign full    = (count == CW'(STACK_DEPTH));
  assign mem_we  = cmd.push && !full;
  assign wr_addr = count[AW-1:0];

  always_comb begin
    count_next = count;
    if (mem_we) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  assign count_dec_next = count_next - CW'(1);
  assign rd_addr        = count_dec_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      op_mem[wr_addr] <= item_code;
    end
    if (mem_we && (wr_addr == rd_addr)) begin
      top <= item_code;
    end else begin
      top <= op_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.out_load && cmd.out_end) begin
        ovf <= 1'b0;
      end else if (cmd.push && full) begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_char <= item.in_char;
      item_end  <= item.expr_end;
      item_code <= char_to_code(item.in_char);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.out_char    <= cmd.out_sel_top ? code_to_char(top) : item_char;
      result.run_last    <= cmd.out_last;
      result.postfix_end <= cmd.out_end;
      result.overflow    <= ovf;
    end
  end

  always_comb begin
    status.in_is_op   = is_op_char(item.in_char);
    status.item_end   = item_end;
    status.item_high  = item_code[1];
    status.count_zero = (count == '0);
    status.count_one  = (count == CW'(1));
    status.top_ge     = top[1] || !item_code[1];
    status.out_free   = !result_valid || !result_stall;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("operator stack count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (count != '0))
    else $error("pop from an empty operator stack");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || !result_stall))
    else $error("result register overwritten while stalled");

  a_end_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_end) |=> ((count == '0) && !ovf))
    else $error("stack or overflow flag left set after end of expression");
`endif

endmodule

/* rtl/core/infix_to_postfix_converter_unit.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit: shunting-yard infix to postfix converter
// Sequence: each character is captured in the item register. An operand is
// then loaded into the result register; an operator first pops each stacked
// operator of equal or higher precedence to the result register, then is
// pushed. A character that closes the expression is followed by a flush
// of the remaining operators. Every emit or pop waits while the result
// register is stalled. A new character is taken only once the last is done.
// Reset: synchronous; empties the stack, clears overflow and output valid.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  isp_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output isp_pkg::out_item_t result
);
  import isp_pkg::*;

  // The controller owns the sequence of steps for one character: it takes
  // the transfer, then either emits an operand or runs the operator pop loop
  // followed by a push, and finally flushes the stack when the character
  // closes the expression. It never looks at payload bits directly; it only
  // sees the status summary produced by the datapath.
  cmd_t    cmd;
  status_t status;

  isp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds the operator stack memory, the captured character,
  // the sticky overflow flag and the result register. The result register
  // decouples the two sides, so a pop proceeds whenever that register is
  // empty or being drained in the same cycle.
  isp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
